// ----- design/drt_pkg.sv -----
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, constants and the arctangent table for the dead reckoning
// tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

  localparam int TRACK_COUNT  = 8;
  localparam int TRK_W        = 3;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
  localparam int QUO_W        = 16;

  // nm per metre * 2^32, CORDIC inverse gain * 2^16, minutes divisor * 2^16
  localparam logic [21:0] NM_PER_M_Q32 = 22'd2319282;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [19:0] TIME_DIV_Q16 = 20'd543582;

  localparam logic signed [47:0] OFF_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] OFF_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAG1,
    OP_MAG2,
    OP_ROT_INIT,
    OP_ROT_STEP,
    OP_ACC,
    OP_VEC_INIT,
    OP_VEC_STEP,
    OP_RNG_LO,
    OP_RNG_HI,
    OP_DIV_INIT,
    OP_DIV_CHK,
    OP_DIV_STEP,
    OP_CLEAR,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic               func;
    logic [2:0]         track_index;
    logic [14:0]        true_airspeed;
    logic [15:0]        heading;
    logic signed [15:0] sideslip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  track_echo;
    logic [31:0] range_nm;
    logic [15:0] return_bearing;
    logic [15:0] return_minutes;
    logic        time_saturated;
  } out_item_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_tab(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/drt_ctrl.sv -----
// ----------------------------------------------------------------------------
// drt_ctrl
// Sequencer: steps the datapath through magnitude, rotate, accumulate,
// vectoring, range scaling and division per update, or through a track clear.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_func,
  input  wire logic [drt_pkg::TRK_W-1:0]  in_track,
  output logic                            in_stall,
  output drt_pkg::dp_cmd_t                cmd,
  input  drt_pkg::dp_stat_t               stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAG1, S_MAG2, S_ROT_INIT, S_ROT, S_ACC, S_VEC_INIT, S_VEC,
    S_RNG_LO, S_RNG_HI, S_DIV_INIT, S_DIV_CHK, S_DIV, S_CLR, S_DONE
  } state_t;

  localparam logic [drt_pkg::STEP_W-1:0] LAST_ROT =
    drt_pkg::STEP_W'(drt_pkg::CORDIC_STEPS - 1);
  localparam logic [drt_pkg::STEP_W-1:0] LAST_DIV =
    drt_pkg::STEP_W'(drt_pkg::QUO_W - 1);

  state_t                      state;
  logic [drt_pkg::STEP_W-1:0]  cnt;
  logic                        track_ok;

  assign track_ok = {1'b0, in_track} < (drt_pkg::TRK_W + 1)'(drt_pkg::TRACK_COUNT);
  assign in_stall = (state != S_IDLE);
  assign cmd.step = cnt;

  always_comb begin
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? drt_pkg::OP_LOAD : drt_pkg::OP_NONE;
      S_MAG1:     cmd.op = drt_pkg::OP_MAG1;
      S_MAG2:     cmd.op = drt_pkg::OP_MAG2;
      S_ROT_INIT: cmd.op = drt_pkg::OP_ROT_INIT;
      S_ROT:      cmd.op = drt_pkg::OP_ROT_STEP;
      S_ACC:      cmd.op = drt_pkg::OP_ACC;
      S_VEC_INIT: cmd.op = drt_pkg::OP_VEC_INIT;
      S_VEC:      cmd.op = drt_pkg::OP_VEC_STEP;
      S_RNG_LO:   cmd.op = drt_pkg::OP_RNG_LO;
      S_RNG_HI:   cmd.op = drt_pkg::OP_RNG_HI;
      S_DIV_INIT: cmd.op = drt_pkg::OP_DIV_INIT;
      S_DIV_CHK:  cmd.op = drt_pkg::OP_DIV_CHK;
      S_DIV:      cmd.op = drt_pkg::OP_DIV_STEP;
      S_CLR:      cmd.op = drt_pkg::OP_CLEAR;
      S_DONE:     cmd.op = stat.out_free ? drt_pkg::OP_OUT : drt_pkg::OP_NONE;
      default:    cmd.op = drt_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid && track_ok) begin
            state <= in_func ? S_CLR : S_MAG1;
          end
        end
        S_MAG1:     state <= S_MAG2;
        S_MAG2:     state <= S_ROT_INIT;
        S_ROT_INIT: state <= S_ROT;
        S_ROT: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_ROT) begin
            cnt   <= '0;
            state <= S_ACC;
          end
        end
        S_ACC:      state <= S_VEC_INIT;
        S_VEC_INIT: state <= S_VEC;
        S_VEC: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_ROT) begin
            cnt   <= '0;
            state <= S_RNG_LO;
          end
        end
        S_RNG_LO:   state <= S_RNG_HI;
        S_RNG_HI:   state <= S_DIV_INIT;
        S_DIV_INIT: state <= S_DIV_CHK;
        S_DIV_CHK:  state <= S_DIV;
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_DIV) begin
            cnt   <= '0;
            state <= S_DONE;
          end
        end
        S_CLR:      state <= S_DONE;
        S_DONE: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/drt_dp.sv -----
// ----------------------------------------------------------------------------
// drt_dp
// Datapath: track offset store, shared CORDIC registers, range scaling,
// restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  drt_pkg::in_item_t        in_data,
  input  wire logic                cfg_wr_en,
  input  wire logic signed [15:0]  cfg_wr_data,
  input  drt_pkg::dp_cmd_t         cmd,
  output drt_pkg::dp_stat_t        stat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output drt_pkg::out_item_t       out_data
);

  logic signed [47:0] east  [drt_pkg::TRACK_COUNT];
  logic signed [47:0] north [drt_pkg::TRACK_COUNT];
  logic signed [15:0] declination;

  logic [drt_pkg::TRK_W-1:0] tr;
  logic [14:0]               tas;
  logic [15:0]               ang16;
  logic [36:0]               mag1;
  logic [36:0]               mag;
  logic signed [50:0]        cx, cy;
  logic signed [33:0]        rz;
  logic [31:0]               vz;
  logic [39:0]               plo;
  logic [47:0]               rq20;
  logic [34:0]               dvs;
  logic [51:0]               rem;
  logic [49:0]               dsh;
  logic [drt_pkg::QUO_W-1:0] q;
  logic                      sat;

  // combinational helpers
  logic signed [33:0] z0;
  logic signed [50:0] mag_s;
  logic signed [50:0] dx, dy;
  logic signed [33:0] tab_r;
  logic [31:0]        tab_v;
  logic signed [50:0] se, sn;
  logic signed [48:0] sum_e, sum_n;
  logic signed [47:0] new_e, new_n;
  logic signed [50:0] ve, vn;
  logic [46:0]        xs;
  logic [38:0]        phi;
  logic [63:0]        tot;
  logic [63:0]        num;
  logic [63:0]        lim;
  logic [44:0]        rng_r;
  logic [31:0]        rng_out;
  logic [15:0]        brg;
  logic [32:0]        ang_r;

  assign stat.out_free = !out_valid || !out_stall;

  always_comb begin
    z0    = {{2{ang16[15]}}, ang16, 16'h0000};
    mag_s = $signed({14'b0, mag});
    dx    = cy >>> cmd.step;
    dy    = cx >>> cmd.step;
    tab_v = drt_pkg::atan_tab(cmd.step);
    tab_r = $signed({2'b00, tab_v});

    se    = (cy + 51'sd8192) >>> 14;
    sn    = (cx + 51'sd8192) >>> 14;
    sum_e = {east[tr][47], east[tr]} + se[48:0];
    sum_n = {north[tr][47], north[tr]} + sn[48:0];
    case (sum_e[48:47])
      2'b01:   new_e = drt_pkg::OFF_MAX;
      2'b10:   new_e = drt_pkg::OFF_MIN;
      default: new_e = sum_e[47:0];
    endcase
    case (sum_n[48:47])
      2'b01:   new_n = drt_pkg::OFF_MAX;
      2'b10:   new_n = drt_pkg::OFF_MIN;
      default: new_n = sum_n[47:0];
    endcase

    vn = {{3{north[tr][47]}}, north[tr]};
    ve = {{3{east[tr][47]}}, east[tr]};

    xs  = cx[50:4];
    phi = 39'(xs[46:24]) * 39'(drt_pkg::INV_GAIN_Q16);
    tot = 64'(plo) + (64'(phi) << 24) + 64'd32768;

    num = {rq20, 16'h0000} + 64'(dvs[34:1]);
    lim = 64'(dvs) << 16;

    rng_r   = 45'((49'(rq20) + 49'd8) >> 4);
    rng_out = (rng_r[44:32] != '0) ? 32'hFFFF_FFFF : rng_r[31:0];
    ang_r   = 33'(vz) + 33'h0_0000_8000;
    brg     = ang_r[31:16] + 16'h8000 - declination;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      declination <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < drt_pkg::TRACK_COUNT; i++) begin
        east[i]  <= '0;
        north[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        declination <= cfg_wr_data;
      end
      if (cmd.op == drt_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        drt_pkg::OP_ACC: begin
          east[tr]  <= new_e;
          north[tr] <= new_n;
        end
        drt_pkg::OP_CLEAR: begin
          east[tr]  <= '0;
          north[tr] <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      drt_pkg::OP_LOAD: begin
        tr    <= in_data.track_index;
        tas   <= in_data.true_airspeed;
        ang16 <= in_data.heading - in_data.sideslip;
      end
      drt_pkg::OP_MAG1: mag1 <= 37'(tas) * 37'(drt_pkg::NM_PER_M_Q32);
      drt_pkg::OP_MAG2: mag  <= 37'((53'(mag1) * 53'(drt_pkg::INV_GAIN_Q16)) >> 16);
      drt_pkg::OP_ROT_INIT: begin
        cy <= '0;
        // fold into the right half plane
        if (z0 > 34'sh0_4000_0000) begin
          cx <= -mag_s;
          rz <= z0 - 34'sh0_8000_0000;
        end else if (z0 < -34'sh0_4000_0000) begin
          cx <= -mag_s;
          rz <= z0 + 34'sh0_8000_0000;
        end else begin
          cx <= mag_s;
          rz <= z0;
        end
      end
      drt_pkg::OP_ROT_STEP: begin
        if (!rz[33]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          rz <= rz - tab_r;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          rz <= rz + tab_r;
        end
      end
      drt_pkg::OP_VEC_INIT: begin
        if (vn < 0) begin
          cx <= -vn;
          cy <= -ve;
          vz <= 32'h8000_0000;
        end else begin
          cx <= vn;
          cy <= ve;
          vz <= '0;
        end
      end
      drt_pkg::OP_VEC_STEP: begin
        if (!cy[50]) begin
          cx <= cx + dx;
          cy <= cy - dy;
          vz <= vz + tab_v;
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          vz <= vz - tab_v;
        end
      end
      drt_pkg::OP_RNG_LO: plo  <= 40'(xs[23:0]) * 40'(drt_pkg::INV_GAIN_Q16);
      drt_pkg::OP_RNG_HI: rq20 <= tot[63:16];
      drt_pkg::OP_DIV_INIT: dvs <= 35'(tas) * 35'(drt_pkg::TIME_DIV_Q16);
      drt_pkg::OP_DIV_CHK: begin
        // quotient above 16 bits, or zero airspeed, saturates
        sat <= (num >= lim);
        rem <= num[51:0];
        dsh <= 50'(dvs) << 15;
        q   <= '0;
      end
      drt_pkg::OP_DIV_STEP: begin
        if (rem >= 52'(dsh)) begin
          rem <= rem - 52'(dsh);
          q   <= {q[drt_pkg::QUO_W-2:0], 1'b1};
        end else begin
          q   <= {q[drt_pkg::QUO_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      drt_pkg::OP_CLEAR: begin
        vz   <= '0;
        rq20 <= '0;
        sat  <= 1'b0;
        q    <= '0;
      end
      drt_pkg::OP_OUT: begin
        out_data.track_echo     <= tr;
        out_data.range_nm       <= rng_out;
        out_data.return_bearing <= brg;
        out_data.return_minutes <= sat ? 16'hFFFF : q;
        out_data.time_saturated <= sat;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/dead_reckoning_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// dead_reckoning_tracker_unit
// Per-track dead reckoning: integrates airspeed steps into east/north
// offsets and reports range, return bearing and time to return.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   input    | in_valid / in_stall  | in_data  (in_item_t)
//   output   | out_valid / out_stall| out_data (out_item_t)
//   config   | cfg_wr_en            | cfg_wr_data (declination)
//
// An update goes from transfer to a loaded result through two multiply
// steps, 16 rotate and 16 vectoring iterations of the shared CORDIC
// registers, and 16 steps of the restoring divider; a clear skips them.
// One item at a time; in_stall is high until the result is in the output
// register. Synchronous reset zeroes all track offsets and the declination.
// ----------------------------------------------------------------------------
`default_nettype none

module dead_reckoning_tracker_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  drt_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output drt_pkg::out_item_t       out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic signed [15:0]  cfg_wr_data
);

  drt_pkg::dp_cmd_t  cmd;
  drt_pkg::dp_stat_t stat;

  drt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_track (in_data.track_index),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  drt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dead reckoning tracker: a directed table, a
// straight run on one track, then random updates and clears, with bursty
// input, random output stalls and declination changes between phases.
// Results are checked against the CORDIC/divider predictor or a hand-typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int RAND_ITEMS  = 1650;
  localparam int WDOG_LIMIT  = 20000;
  localparam int FUNC_UPDATE = 0;
  localparam int FUNC_CLEAR  = 1;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  drt_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  drt_pkg::out_item_t out_data;
  logic cfg_wr_en;
  logic signed [15:0] cfg_wr_data;

  dead_reckoning_tracker_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor state
  logic [15:0] decl_q;
  logic signed [63:0] east_q[drt_pkg::TRACK_COUNT];
  logic signed [63:0] north_q[drt_pkg::TRACK_COUNT];
  drt_pkg::out_item_t expected_q[$];
  int errors;
  int idle_cycles;

  function automatic logic signed [63:0] asr(input logic signed [63:0] v, input int n);
    return v >>> n;
  endfunction

  function automatic logic signed [63:0] sat48(input logic signed [63:0] s);
    if (s > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return s;
  endfunction

  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] t[24];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
          32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
          32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
          32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
          32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  // Advance one track and return the position report it produces.
  function automatic drt_pkg::out_item_t dead_reckon(input drt_pkg::in_item_t it);
    drt_pkg::out_item_t r;
    logic signed [63:0] x, y, z, dx, dy, mag;
    logic [63:0] rq20, rout, mins, dv, q, xm;
    logic [31:0] ang;
    logic [15:0] rot;
    int t;
    t = it.track_index;
    rq20 = 0; ang = 0; mins = 0;
    r.time_saturated = 1'b0;
    if (it.func == FUNC_CLEAR) begin
      east_q[t] = 0;
      north_q[t] = 0;
    end else begin
      mag = (64'(it.true_airspeed) * 64'(drt_pkg::NM_PER_M_Q32) *
             64'(drt_pkg::INV_GAIN_Q16)) >> 16;
      rot = it.heading - it.sideslip;
      z = {32'b0, rot, 16'b0};
      if (z >= 64'sh8000_0000) z = z - 64'sh1_0000_0000;
      x = mag; y = 0;
      if (z > 64'sh4000_0000) begin
        x = -x; z = z - 64'sh8000_0000;
      end else if (z < -64'sh4000_0000) begin
        x = -x; z = z + 64'sh8000_0000;
      end
      for (int i = 0; i < drt_pkg::CORDIC_STEPS; i++) begin
        dx = asr(y, i); dy = asr(x, i);
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - $signed({32'b0, atan_step(i)});
        end else begin
          x = x + dx; y = y - dy; z = z + $signed({32'b0, atan_step(i)});
        end
      end
      east_q[t] = sat48(east_q[t] + asr(y + 8192, 14));
      north_q[t] = sat48(north_q[t] + asr(x + 8192, 14));
      // vectoring on (north, east)
      x = north_q[t]; y = east_q[t];
      if (x < 0) begin
        x = -x; y = -y; ang = 32'h8000_0000;
      end
      for (int i = 0; i < drt_pkg::CORDIC_STEPS; i++) begin
        dx = asr(y, i); dy = asr(x, i);
        if (y >= 0) begin
          x = x + dx; y = y - dy; ang = ang + atan_step(i);
        end else begin
          x = x - dx; y = y + dy; ang = ang - atan_step(i);
        end
      end
      xm = x;
      rq20 = ((xm >> 4) * 64'(drt_pkg::INV_GAIN_Q16) + 64'd32768) >> 16;
      if (it.true_airspeed == 0) begin
        mins = 64'hFFFF; r.time_saturated = 1'b1;
      end else begin
        dv = 64'(it.true_airspeed) * 64'(drt_pkg::TIME_DIV_Q16);
        q = ((rq20 << 16) + dv / 2) / dv;
        if (q > 64'hFFFF) begin
          mins = 64'hFFFF; r.time_saturated = 1'b1;
        end else begin
          mins = q;
        end
      end
    end
    rout = (rq20 + 8) >> 4;
    if (rout > 64'hFFFF_FFFF) rout = 64'hFFFF_FFFF;
    r.track_echo = it.track_index;
    r.range_nm = rout[31:0];
    r.return_bearing = 16'((64'(ang) + 64'h8000) >> 16) + 16'h8000 - decl_q;
    r.return_minutes = mins[15:0];
    return r;
  endfunction

  // directed table; a row with fixed_ok set carries a hand-typed result
  typedef struct {
    drt_pkg::in_item_t  item;
    bit                 fixed_ok;
    drt_pkg::out_item_t fixed;
  } dir_row_t;
  dir_row_t dir_tab[$];

  function automatic drt_pkg::in_item_t mk(input bit f, input int trk, input int tas,
                                           input int hdg, input int slip);
    drt_pkg::in_item_t it;
    it.func = f; it.track_index = trk[2:0]; it.true_airspeed = tas[14:0];
    it.heading = hdg[15:0]; it.sideslip = slip[15:0];
    return it;
  endfunction

  function automatic drt_pkg::out_item_t res(input int trk, input logic [31:0] rng,
                                             input int brg, input int mins, input bit sat);
    drt_pkg::out_item_t r;
    r.track_echo = trk[2:0]; r.range_nm = rng; r.return_bearing = brg[15:0];
    r.return_minutes = mins[15:0]; r.time_saturated = sat;
    return r;
  endfunction

  // ---- input driver ----
  int sent;
  task automatic send_item(input drt_pkg::in_item_t it, input bit has_fixed,
                           input drt_pkg::out_item_t fx);
    drt_pkg::out_item_t p;
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = dead_reckon(it);
    if (has_fixed && p !== fx)
      $display("%0t directed row disagrees with predictor exp=%h got=%h", $time, fx, p);
    expected_q.push_back(has_fixed ? fx : p);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_decl(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    decl_q = v;
  endtask

  function automatic drt_pkg::in_item_t rand_item();
    drt_pkg::in_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.func = (sel < 6) ? 1'b1 : 1'b0;
    it.track_index = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: it.true_airspeed = '0;
      1: it.true_airspeed = 15'h7FFF;
      2: it.true_airspeed = 15'($urandom_range(1, 64));
      default: it.true_airspeed = 15'($urandom);
    endcase
    it.heading = 16'($urandom);
    it.sideslip = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 4000) - 2000)
                                         : 16'($urandom);
    return it;
  endfunction

  // ---- output monitor ----
  always @(posedge clk) begin
    drt_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected transfer got=%h", $time, out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.track_echo !== e.track_echo)
          $display("%0t track_echo exp=%0d got=%0d", $time, e.track_echo, out_data.track_echo);
        if (out_data.range_nm !== e.range_nm)
          $display("%0t range_nm exp=%h got=%h", $time, e.range_nm, out_data.range_nm);
        if (out_data.return_bearing !== e.return_bearing)
          $display("%0t return_bearing exp=%h got=%h", $time, e.return_bearing,
                   out_data.return_bearing);
        if (out_data.return_minutes !== e.return_minutes)
          $display("%0t return_minutes exp=%h got=%h", $time, e.return_minutes,
                   out_data.return_minutes);
        if (out_data.time_saturated !== e.time_saturated)
          $display("%0t time_saturated exp=%b got=%b", $time, e.time_saturated,
                   out_data.time_saturated);
        if (out_data !== e) errors++;
      end
    end
  end

  // receiver stall pattern: random stretches of no, light and heavy stalls
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] decl_set[5];
    int phase_len;
    decl_set = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h1234};
    rst = 1'b1; in_valid = 1'b0; in_data = '0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    errors = 0; idle_cycles = 0; sent = 0; decl_q = '0;
    for (int i = 0; i < drt_pkg::TRACK_COUNT; i++) begin
      east_q[i] = 0; north_q[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero-position, zero-airspeed, extremes, clears, all quadrants
    dir_tab.push_back('{mk(FUNC_CLEAR, 0, 0, 0, 0), 1, res(0, 0, 16'h8000, 0, 0)});
    dir_tab.push_back('{mk(FUNC_UPDATE, 1, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 7, 32767, 0, 0), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 7, 32767, 16'h4000, 0), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 7, 32767, 16'h8000, 0), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 7, 32767, 16'hC000, 0), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 2, 1, 16'hFFFF, -32768), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 2, 32767, 0, 32767), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 3, 12345, 16'h2000, -100), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 3, 0, 16'h2000, 0), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 4, 21845, 16'hAAAA, 16'h5555), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 5, 10922, 16'h5555, -21846), 0, '0});
    dir_tab.push_back('{mk(FUNC_CLEAR, 7, 32767, 16'hFFFF, -1), 1,
                        res(7, 0, 16'h8000, 0, 0)});
    dir_tab.push_back('{mk(FUNC_UPDATE, 7, 100, 16'h8001, 1), 0, '0});
    dir_tab.push_back('{mk(FUNC_UPDATE, 6, 1, 16'h4000, 16'h4000), 0, '0});
    dir_tab.push_back('{mk(FUNC_CLEAR, 3, 0, 0, 0), 1, res(3, 0, 16'h8000, 0, 0)});
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].fixed_ok, dir_tab[i].fixed);
    drain();

    // long straight run on one track, then random phases
    for (int i = 0; i < 5; i++) begin
      write_decl(decl_set[i]);
      phase_len = (i == 0) ? 60 : RAND_ITEMS / 4;
      for (int k = 0; k < phase_len; k++) begin
        if (i == 0) send_item(mk(FUNC_UPDATE, 0, 32767, 16'h1000, 0), 0, '0);
        else send_item(rand_item(), 0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
